### hdl/catmull_rom_path_evaluator_unit_macros.svh
// ----------------------------------------------------------------------------
// Catmull-Rom path evaluator assertion macros
// Shared property shorthands for the evaluator's assertions.
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_PATH_EVALUATOR_UNIT_MACROS_SVH
`define CATMULL_ROM_PATH_EVALUATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CRPE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CRPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/crpe_pkg.sv
// ----------------------------------------------------------------------------
// Catmull-Rom path evaluator package
// Widths, modes, sequencer states and lane control shared by the design.
// ----------------------------------------------------------------------------
package crpe_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int PW             = 32;   // coordinate width
    localparam int TW             = 17;   // curve parameter width, Q1.16
    localparam int IDX_W          = 6;    // point_index width
    localparam int CNT_W          = 7;    // point_count width
    localparam int COEF_W         = 37;   // spline coefficient width
    localparam int PROD_W         = 55;   // coefficient times parameter
    localparam int SUM_W          = 42;   // accumulated sum width
    localparam logic [TW-1:0] T_ONE = 17'h10000;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_POINT,
        MODE_LINE,
        MODE_SPLINE
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SEG,
        ST_READ,
        ST_LAST,
        ST_COEF,
        ST_MUL,
        ST_SUM,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic coef_en;
        logic mul_en;
        logic sum_en;
    } lane_ctl_t;

endpackage

### hdl/crpe_req_if.sv
// ----------------------------------------------------------------------------
// Request and result channels
// Valid/ready channels carrying request beats and result beats.
// ----------------------------------------------------------------------------
interface crpe_req_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    func;
    logic        [crpe_pkg::IDX_W-1:0]       point_index;
    logic signed [crpe_pkg::PW-1:0]          coord_x;
    logic signed [crpe_pkg::PW-1:0]          coord_y;
    logic signed [crpe_pkg::PW-1:0]          coord_z;
    logic        [crpe_pkg::TW-1:0]          curve_param;

    modport source (output valid, func, point_index, coord_x, coord_y, coord_z,
                    curve_param, input ready);
    modport sink (input valid, func, point_index, coord_x, coord_y, coord_z,
                  curve_param, output ready);
endinterface

interface crpe_rsp_if;
    logic                           valid;
    logic                           ready;
    logic signed [crpe_pkg::PW-1:0] pos_x;
    logic signed [crpe_pkg::PW-1:0] pos_y;
    logic signed [crpe_pkg::PW-1:0] pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

### hdl/catmull_rom_path_evaluator_unit.sv
// ----------------------------------------------------------------------------
// Catmull-Rom path evaluator
// Control point store and uniform Catmull-Rom evaluation in three lanes.
// ----------------------------------------------------------------------------
// Write beats with an index inside the store are written to it. An evaluate
// beat steps through scaling, segment selection, four store reads, coefficients,
// products and sum, then loads the output register once any held result is taken.
// A new beat is accepted only while the sequencer is idle, so evaluations never overlap.
// Reset clears the sequencer, the output valid and point_count; the point
// store is not cleared and holds nothing meaningful until written.
// ----------------------------------------------------------------------------
`include "catmull_rom_path_evaluator_unit_macros.svh"

module catmull_rom_path_evaluator_unit #(
    parameter int MAX_POINTS = crpe_pkg::MAX_POINTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    crpe_req_if.sink    req,
    crpe_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Address width of the store and a count width that can hold MAX_POINTS
    // as well as any point_count or point_index value.
    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW  = ((AW + 1 > crpe_pkg::CNT_W) ? AW + 1 : crpe_pkg::CNT_W) + 1;
    localparam int TW  = crpe_pkg::TW;
    localparam int PW  = crpe_pkg::PW;
    localparam int SCW = TW + CW;

    localparam logic [CW-1:0] MAX_C = CW'(MAX_POINTS);

    // ------------------------------------------------------------------
    // Configuration register. Only register index 0 exists; the upper
    // address bit selects the register index.
    // ------------------------------------------------------------------
    logic [crpe_pkg::CNT_W-1:0] point_count_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(point_count_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr[2] == 1'b0))
        begin
            point_count_reg <= pwdata[crpe_pkg::CNT_W-1:0];
        end
    end

    // Counts above the store depth behave as a full store.
    logic [CW-1:0] cnt_ext;
    logic [CW-1:0] cnt_eff;
    logic [CW-1:0] n_pts;

    assign cnt_ext = CW'(point_count_reg);
    assign cnt_eff = (cnt_ext > MAX_C) ? MAX_C : cnt_ext;
    assign n_pts   = cnt_eff - CW'(1);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    crpe_pkg::state_t state_reg, state_next;

    logic                 acc;
    logic                 acc_eval;
    logic                 acc_write;
    logic [CW-1:0]        wr_idx_ext;
    logic [TW-1:0]        t_reg;
    logic [SCW-1:0]       s_reg;
    logic [1:0]           rd_cnt_reg;
    logic                 cap_en_reg;
    logic [1:0]           cap_sel_reg;
    logic [AW-1:0]        idx_reg [4];
    logic [AW-1:0]        idx_next [4];
    crpe_pkg::mode_t      mode_reg, mode_next;
    logic [TW-1:0]        lt_reg, lt_next;
    logic [TW-1:0]        t2_reg;
    logic [TW-1:0]        t3_reg;
    logic [2*TW-1:0]      sq_prod;
    logic [CW:0]          seg_raw;
    logic [CW:0]          seg;
    logic [CW:0]          n_wide;
    logic [CW:0]          i0_w, i3_w;
    logic [SCW-1:0]       lt_wide;
    logic                 rd_en;
    logic                 fin_load;
    crpe_pkg::lane_ctl_t  lane_ctl;

    assign acc       = req.valid && req.ready;
    assign acc_eval  = acc && (req.func == crpe_pkg::FUNC_EVAL);
    assign acc_write = acc && (req.func == crpe_pkg::FUNC_WRITE);
    assign wr_idx_ext = CW'(req.point_index);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crpe_pkg::ST_IDLE:
            begin
                if (acc_eval)
                begin
                    state_next = crpe_pkg::ST_SCALE;
                end
            end
            crpe_pkg::ST_SCALE: state_next = crpe_pkg::ST_SEG;
            crpe_pkg::ST_SEG:   state_next = crpe_pkg::ST_READ;
            crpe_pkg::ST_READ:
            begin
                if (rd_cnt_reg == 2'd3)
                begin
                    state_next = crpe_pkg::ST_LAST;
                end
            end
            crpe_pkg::ST_LAST:  state_next = crpe_pkg::ST_COEF;
            crpe_pkg::ST_COEF:  state_next = crpe_pkg::ST_MUL;
            crpe_pkg::ST_MUL:   state_next = crpe_pkg::ST_SUM;
            crpe_pkg::ST_SUM:   state_next = crpe_pkg::ST_FIN;
            crpe_pkg::ST_FIN:
            begin
                if (fin_load)
                begin
                    state_next = crpe_pkg::ST_IDLE;
                end
            end
            default:            state_next = crpe_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        req.ready        = 1'b0;
        rd_en            = 1'b0;
        lane_ctl.coef_en = 1'b0;
        lane_ctl.mul_en  = 1'b0;
        lane_ctl.sum_en  = 1'b0;
        fin_load         = 1'b0;
        case (state_reg)
            crpe_pkg::ST_IDLE: req.ready        = 1'b1;
            crpe_pkg::ST_READ: rd_en            = 1'b1;
            crpe_pkg::ST_COEF: lane_ctl.coef_en = 1'b1;
            crpe_pkg::ST_MUL:  lane_ctl.mul_en  = 1'b1;
            crpe_pkg::ST_SUM:  lane_ctl.sum_en  = 1'b1;
            crpe_pkg::ST_FIN:  fin_load         = !rsp.valid || rsp.ready;
            default:           req.ready        = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= crpe_pkg::ST_IDLE;
            rd_cnt_reg  <= '0;
            cap_en_reg  <= 1'b0;
            cap_sel_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cap_en_reg  <= rd_en;
            cap_sel_reg <= rd_cnt_reg;
            if (state_reg == crpe_pkg::ST_SEG)
            begin
                rd_cnt_reg <= '0;
            end
            else if (rd_en)
            begin
                rd_cnt_reg <= rd_cnt_reg + 2'd1;
            end
        end
    end

    // Segment selection: s = t * (count - 1), the segment is its integer part
    // clamped to the last segment, and neighbours are clamped to the path.
    assign seg_raw = s_reg[SCW-1:16];
    assign n_wide  = {1'b0, n_pts};
    assign seg     = (seg_raw > n_wide - (CW+1)'(1)) ? n_wide - (CW+1)'(1) : seg_raw;
    assign i0_w    = (seg == '0) ? '0 : seg - (CW+1)'(1);
    assign i3_w    = (seg + (CW+1)'(2) > n_wide) ? n_wide : seg + (CW+1)'(2);
    assign lt_wide = s_reg - (SCW'(seg) << 16);

    always_comb
    begin
        idx_next[0] = '0;
        idx_next[1] = '0;
        idx_next[2] = '0;
        idx_next[3] = '0;
        lt_next     = t_reg;
        if (cnt_eff == '0)
        begin
            mode_next = crpe_pkg::MODE_ZERO;
        end
        else if (cnt_eff == CW'(1))
        begin
            mode_next = crpe_pkg::MODE_POINT;
        end
        else if (cnt_eff == CW'(2))
        begin
            mode_next   = crpe_pkg::MODE_LINE;
            idx_next[1] = AW'(1);
        end
        else
        begin
            mode_next   = crpe_pkg::MODE_SPLINE;
            idx_next[0] = i0_w[AW-1:0];
            idx_next[1] = seg[AW-1:0];
            idx_next[2] = AW'(seg + (CW+1)'(1));
            idx_next[3] = i3_w[AW-1:0];
            lt_next     = lt_wide[TW-1:0];
        end
    end

    // Powers of the local parameter are formed during the store reads.
    assign sq_prod = (rd_cnt_reg == 2'd0) ? lt_reg * lt_reg : t2_reg * lt_reg;

    always_ff @(posedge clk)
    begin
        if (acc_eval)
        begin
            t_reg <= (req.curve_param > crpe_pkg::T_ONE) ? crpe_pkg::T_ONE
                                                         : req.curve_param;
        end
        if (state_reg == crpe_pkg::ST_SCALE)
        begin
            s_reg <= SCW'(t_reg) * SCW'(n_pts);
        end
        if (state_reg == crpe_pkg::ST_SEG)
        begin
            idx_reg  <= idx_next;
            mode_reg <= mode_next;
            lt_reg   <= lt_next;
        end
        if (rd_en && (rd_cnt_reg == 2'd0))
        begin
            t2_reg <= sq_prod[TW+15:16];
        end
        if (rd_en && (rd_cnt_reg == 2'd1))
        begin
            t3_reg <= sq_prod[TW+15:16];
        end
    end

    // ------------------------------------------------------------------
    // Point store and neighbour capture.
    // ------------------------------------------------------------------
    logic [3*PW-1:0]      rd_data;
    logic signed [PW-1:0] px_reg [4];
    logic signed [PW-1:0] py_reg [4];
    logic signed [PW-1:0] pz_reg [4];

    crpe_store #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (acc_write && (wr_idx_ext < MAX_C)),
        .wr_addr (wr_idx_ext[AW-1:0]),
        .wr_data ({req.coord_z, req.coord_y, req.coord_x}),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[rd_cnt_reg]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cap_en_reg)
        begin
            px_reg[cap_sel_reg] <= rd_data[PW-1:0];
            py_reg[cap_sel_reg] <= rd_data[2*PW-1:PW];
            pz_reg[cap_sel_reg] <= rd_data[3*PW-1:2*PW];
        end
    end

    // ------------------------------------------------------------------
    // Lanes: one per coordinate, all run in lockstep.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] res_x, res_y, res_z;

    crpe_lane u_lane_x (
        .clk (clk), .ctl (lane_ctl), .mode (mode_reg),
        .p0 (px_reg[0]), .p1 (px_reg[1]), .p2 (px_reg[2]), .p3 (px_reg[3]),
        .lt (lt_reg), .t2 (t2_reg), .t3 (t3_reg), .result (res_x)
    );

    crpe_lane u_lane_y (
        .clk (clk), .ctl (lane_ctl), .mode (mode_reg),
        .p0 (py_reg[0]), .p1 (py_reg[1]), .p2 (py_reg[2]), .p3 (py_reg[3]),
        .lt (lt_reg), .t2 (t2_reg), .t3 (t3_reg), .result (res_y)
    );

    crpe_lane u_lane_z (
        .clk (clk), .ctl (lane_ctl), .mode (mode_reg),
        .p0 (pz_reg[0]), .p1 (pz_reg[1]), .p2 (pz_reg[2]), .p3 (pz_reg[3]),
        .lt (lt_reg), .t2 (t2_reg), .t3 (t3_reg), .result (res_z)
    );

    // ------------------------------------------------------------------
    // Merge stage: the three lane results form one result beat, held in an
    // output register until the sink takes it.
    // ------------------------------------------------------------------
    logic                 rsp_valid_reg;
    logic signed [PW-1:0] pos_x_reg, pos_y_reg, pos_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fin_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            pos_x_reg <= res_x;
            pos_y_reg <= res_y;
            pos_z_reg <= res_z;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.pos_x = pos_x_reg;
    assign rsp.pos_y = pos_y_reg;
    assign rsp.pos_z = pos_z_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `CRPE_ASSERT_NEXT(a_eval_starts, acc_eval, state_reg == crpe_pkg::ST_SCALE,
        "evaluate beat did not start the sequencer")
    `CRPE_ASSERT_NEXT(a_write_stays_idle, acc_write, state_reg == crpe_pkg::ST_IDLE,
        "write beat left the idle state")
    `CRPE_ASSERT_NEXT(a_fin_loads_result, fin_load, rsp_valid_reg,
        "finished evaluation did not present a result")
    `CRPE_ASSERT_NOW(a_no_read_outside, rd_en, !req.ready,
        "store read while accepting beats")

endmodule

### hdl/crpe_store.sv
// ----------------------------------------------------------------------------
// Control point store
// Memory of x, y and z per slot with separate write and read ports and a registered read.
// ----------------------------------------------------------------------------
module crpe_store #(
    parameter int DEPTH = crpe_pkg::MAX_POINTS_DEF,
    parameter int AW    = $clog2(crpe_pkg::MAX_POINTS_DEF)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [3*crpe_pkg::PW-1:0]    wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [3*crpe_pkg::PW-1:0]    rd_data
);

    logic [3*crpe_pkg::PW-1:0] mem [DEPTH];
    logic [3*crpe_pkg::PW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/crpe_lane.sv
// ----------------------------------------------------------------------------
// Evaluator lane
// Coefficients, products and saturated sum for one coordinate.
// ----------------------------------------------------------------------------
module crpe_lane (
    input  logic                            clk,
    input  crpe_pkg::lane_ctl_t             ctl,
    input  crpe_pkg::mode_t                 mode,
    input  logic signed [crpe_pkg::PW-1:0]  p0,
    input  logic signed [crpe_pkg::PW-1:0]  p1,
    input  logic signed [crpe_pkg::PW-1:0]  p2,
    input  logic signed [crpe_pkg::PW-1:0]  p3,
    input  logic        [crpe_pkg::TW-1:0]  lt,
    input  logic        [crpe_pkg::TW-1:0]  t2,
    input  logic        [crpe_pkg::TW-1:0]  t3,
    output logic signed [crpe_pkg::PW-1:0]  result
);

    localparam int CW = crpe_pkg::COEF_W;
    localparam int QW = crpe_pkg::PROD_W;
    localparam int SW = crpe_pkg::SUM_W;

    logic signed [CW-1:0] e0, e1, e2, e3;
    logic signed [CW-1:0] ca_next, cb_next, cc_next, cd_next;
    logic signed [CW-1:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic signed [CW-1:0] a_d_reg;
    logic signed [QW-1:0] pb_reg, pc_reg, pd_reg;
    logic                 half_reg;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] sum_sh;
    logic signed [crpe_pkg::PW-1:0] result_next;
    logic signed [crpe_pkg::PW-1:0] result_reg;

    assign e0 = CW'(p0);
    assign e1 = CW'(p1);
    assign e2 = CW'(p2);
    assign e3 = CW'(p3);

    // Spline uses a = 2p1, b = p2 - p0, c = 2p0 - 5p1 + 4p2 - p3 and
    // d = -p0 + 3p1 - 3p2 + p3; the linear case reuses b as the slope.
    always_comb
    begin
        ca_next = '0;
        cb_next = '0;
        cc_next = '0;
        cd_next = '0;
        case (mode)
            crpe_pkg::MODE_ZERO:
            begin
                ca_next = '0;
            end
            crpe_pkg::MODE_POINT:
            begin
                ca_next = e0;
            end
            crpe_pkg::MODE_LINE:
            begin
                ca_next = e0;
                cb_next = e1 - e0;
            end
            crpe_pkg::MODE_SPLINE:
            begin
                ca_next = e1 <<< 1;
                cb_next = e2 - e0;
                cc_next = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
                cd_next = ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3 - e0;
            end
            default:
            begin
                ca_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.coef_en)
        begin
            ca_reg   <= ca_next;
            cb_reg   <= cb_next;
            cc_reg   <= cc_next;
            cd_reg   <= cd_next;
            half_reg <= (mode == crpe_pkg::MODE_SPLINE);
        end
        if (ctl.mul_en)
        begin
            a_d_reg <= ca_reg;
            pb_reg  <= cb_reg * $signed({1'b0, lt});
            pc_reg  <= cc_reg * $signed({1'b0, t2});
            pd_reg  <= cd_reg * $signed({1'b0, t3});
        end
        if (ctl.sum_en)
        begin
            result_reg <= result_next;
        end
    end

    // Arithmetic shifts floor toward minus infinity, as the products require.
    assign sum = SW'(a_d_reg) + SW'(pb_reg >>> 16) + SW'(pc_reg >>> 16)
               + SW'(pd_reg >>> 16);
    assign sum_sh = half_reg ? (sum >>> 1) : sum;

    always_comb
    begin
        if (sum_sh > SW'(signed'(33'sh0_7FFF_FFFF)))
        begin
            result_next = {1'b0, {(crpe_pkg::PW-1){1'b1}}};
        end
        else if (sum_sh < SW'(signed'(33'sh1_8000_0000)))
        begin
            result_next = {1'b1, {(crpe_pkg::PW-1){1'b0}}};
        end
        else
        begin
            result_next = sum_sh[crpe_pkg::PW-1:0];
        end
    end

    assign result = result_reg;

endmodule
